// ----- rtl/dcif_pkg.sv -----
// Package for the dual console input FIFO: command and source codes,
// field widths and default ring depth. No dependencies.
package dcif_pkg;

  localparam int RING_DEPTH_DEF = 512;
  localparam int CMD_W          = 3;
  localparam int SRC_W          = 2;
  localparam int BYTE_W         = 8;
  localparam int KFREE_W        = 9;

  localparam logic [BYTE_W-1:0] CTRL_C_BYTE = 8'h03;

  localparam logic [CMD_W-1:0] CMD_PUSH_KBD   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_REPLY = 3'd1;
  localparam logic [CMD_W-1:0] CMD_GET        = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PEEK       = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY_FREE = 3'd4;
  localparam logic [CMD_W-1:0] CMD_FLUSH      = 3'd5;

  localparam logic [SRC_W-1:0] SRC_ANY    = 2'd0;
  localparam logic [SRC_W-1:0] SRC_KBD    = 2'd1;
  localparam logic [SRC_W-1:0] SRC_UART   = 2'd2;
  localparam logic [SRC_W-1:0] SRC_TELNET = 2'd3;

endpackage

// ----- rtl/dcif_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
module dcif_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/dual_console_input_fifo_top.sv -----
// Top level of the dual console input FIFO: keyboard ring and reply ring
// in two dcif_ram instances, pointers and command sequencer. Uses dcif_pkg.
//
//   Channel  Direction  Handshake              Payload
//   in_      slave      in_tvalid / in_tready  in_tuser command, source_sel;
//                                              in_tdata data_byte
//   out_     master     out_tvalid/out_tready  out_tdata result fields
//
// Each request goes through the sequencer in order: accept, a cycle
// in which the RAMs read at the current read pointers, and the execute cycle
// that updates pointers, writes a pushed byte and loads the result register.
// in_tready is high only while the sequencer is idle. A result waiting in the
// output register does not block the next accept; the execute cycle waits
// until the output register is free. Reset (rst_n low, synchronous) empties
// both rings and the output register. The RAM contents are not cleared.
module dual_console_input_fifo_top #(
  parameter int RING_DEPTH = dcif_pkg::RING_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input requests.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [4:0]  in_tuser,   // [2:0] command, [4:3] source_sel
  // Results, one per request.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [0] char_valid, [8:1] char_value,
                                  // [10:9] src_out, [11] sigint,
                                  // [20:12] kbd_free, [21] dropped, rest zero
);

  localparam int PW  = $clog2(RING_DEPTH);
  localparam int PW1 = PW + 1;
  localparam logic [PW-1:0]  PTR_LAST = PW'(RING_DEPTH - 1);
  localparam logic [PW1-1:0] DEPTH_W  = PW1'(RING_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Latched request.
  logic [dcif_pkg::CMD_W-1:0]  cmd_r;
  logic [dcif_pkg::SRC_W-1:0]  sel_r;
  logic [dcif_pkg::BYTE_W-1:0] byte_r;

  // Ring pointers.
  logic [PW-1:0] kwp_r, kwp_nxt, krp_r, krp_nxt;
  logic [PW-1:0] rwp_r, rwp_nxt, rrp_r, rrp_nxt;

  // RAM ports.
  logic                        kbd_we, rep_we;
  logic [dcif_pkg::BYTE_W-1:0] kbd_rd, rep_rd;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic [23:0] out_data_r, out_data_nxt;

  // Result fields of the execute cycle.
  logic                         res_valid, res_sig, res_drop;
  logic [dcif_pkg::BYTE_W-1:0]  res_value;
  logic [dcif_pkg::SRC_W-1:0]   res_src;
  logic [dcif_pkg::KFREE_W-1:0] res_free;
  logic [PW1-1:0]               free_raw, free_mod;

  logic in_fire, exec_fire, out_room;
  logic kbd_empty, rep_empty, kbd_full, rep_full;

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PW'(1);
  endfunction

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_room   = !out_valid_r || out_tready;
  assign exec_fire  = (state_r == S_EXEC) && out_room;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign kbd_empty = (kwp_r == krp_r);
  assign rep_empty = (rwp_r == rrp_r);
  assign kbd_full  = (advance(kwp_r) == krp_r);
  assign rep_full  = (advance(rwp_r) == rrp_r);

  // Both rings are read at their read pointers every cycle. Pointers and
  // RAM contents only change in the execute cycle, and the read cycle
  // that follows every accept refreshes the read data before it is used.
  dcif_ram #(
    .WIDTH (dcif_pkg::BYTE_W),
    .DEPTH (RING_DEPTH)
  ) u_kbd_ram (
    .clk     (clk),
    .wr_en   (kbd_we),
    .wr_addr (kwp_r),
    .wr_data (byte_r),
    .rd_addr (krp_r),
    .rd_data (kbd_rd)
  );

  dcif_ram #(
    .WIDTH (dcif_pkg::BYTE_W),
    .DEPTH (RING_DEPTH)
  ) u_reply_ram (
    .clk     (clk),
    .wr_en   (rep_we),
    .wr_addr (rwp_r),
    .wr_data (byte_r),
    .rd_addr (rrp_r),
    .rd_data (rep_rd)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (exec_fire) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Command execution. Everything here is committed only on exec_fire.
  always_comb begin
    kwp_nxt   = kwp_r;
    krp_nxt   = krp_r;
    rwp_nxt   = rwp_r;
    rrp_nxt   = rrp_r;
    kbd_we    = 1'b0;
    rep_we    = 1'b0;
    res_valid = 1'b0;
    res_value = '0;
    res_src   = dcif_pkg::SRC_ANY;
    res_sig   = 1'b0;
    res_drop  = 1'b0;
    case (cmd_r)
      dcif_pkg::CMD_PUSH_KBD: begin
        res_sig = (byte_r == dcif_pkg::CTRL_C_BYTE);
        if (kbd_full) begin
          res_drop = 1'b1;
        end else begin
          kbd_we  = exec_fire;
          kwp_nxt = advance(kwp_r);
        end
      end
      dcif_pkg::CMD_PUSH_REPLY: begin
        if (rep_full) begin
          res_drop = 1'b1;
        end else begin
          rep_we  = exec_fire;
          rwp_nxt = advance(rwp_r);
        end
      end
      dcif_pkg::CMD_GET: begin
        case (sel_r)
          dcif_pkg::SRC_ANY: begin
            // The reply ring has priority over the keyboard ring.
            if (!rep_empty) begin
              res_valid = 1'b1;
              res_value = rep_rd;
              res_src   = dcif_pkg::SRC_UART;
              rrp_nxt   = advance(rrp_r);
            end else if (!kbd_empty) begin
              res_valid = 1'b1;
              res_value = kbd_rd;
              res_src   = dcif_pkg::SRC_KBD;
              krp_nxt   = advance(krp_r);
            end
          end
          dcif_pkg::SRC_KBD: begin
            if (!kbd_empty) begin
              res_valid = 1'b1;
              res_value = kbd_rd;
              res_src   = dcif_pkg::SRC_KBD;
              krp_nxt   = advance(krp_r);
            end
          end
          default: begin
            // Uart and telnet share the reply ring.
            if (!rep_empty) begin
              res_valid = 1'b1;
              res_value = rep_rd;
              res_src   = dcif_pkg::SRC_UART;
              rrp_nxt   = advance(rrp_r);
            end
          end
        endcase
      end
      dcif_pkg::CMD_PEEK: begin
        // A peek from any source picks no ring and finds nothing.
        case (sel_r)
          dcif_pkg::SRC_ANY: begin
            res_valid = 1'b0;
          end
          dcif_pkg::SRC_KBD: begin
            if (!kbd_empty) begin
              res_valid = 1'b1;
              res_value = kbd_rd;
            end
          end
          default: begin
            if (!rep_empty) begin
              res_valid = 1'b1;
              res_value = rep_rd;
            end
          end
        endcase
      end
      dcif_pkg::CMD_FLUSH: begin
        kwp_nxt = '0;
        krp_nxt = '0;
        rwp_nxt = '0;
        rrp_nxt = '0;
      end
      default: begin
        // Free-space query and unused codes change nothing.
      end
    endcase

    // Keyboard free space after the command: (rp + depth - wp - 1) mod depth.
    free_raw = {1'b0, krp_nxt} + DEPTH_W - {1'b0, kwp_nxt} - PW1'(1);
    free_mod = (free_raw >= DEPTH_W) ? free_raw - DEPTH_W : free_raw;
    res_free = dcif_pkg::KFREE_W'(free_mod);

    out_data_nxt = {2'b00, res_drop, res_free, res_sig, res_src, res_value, res_valid};
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (exec_fire) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      kwp_r       <= '0;
      krp_r       <= '0;
      rwp_r       <= '0;
      rrp_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (exec_fire) begin
        kwp_r <= kwp_nxt;
        krp_r <= krp_nxt;
        rwp_r <= rwp_nxt;
        rrp_r <= rrp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r  <= in_tuser[2:0];
      sel_r  <= in_tuser[4:3];
      byte_r <= in_tdata;
    end
    if (exec_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// ----- rtl/dcif_checker.sv -----
// Port-level checker for the dual console input FIFO and its bind to
// dual_console_input_fifo_top. Depends on the top level's port list.
module dcif_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // The block works on one request at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while another is in work");

  // Nothing found means zero value and no serving source.
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[10:1] == 10'd0)
    else $error("empty result carries a value or source");

  // Push results that flag sigint or a drop never carry a character.
  a_push_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[11] || out_tdata[21]) |-> !out_tdata[0])
    else $error("push result carries a character");

endmodule

bind dual_console_input_fifo_top dcif_checker u_dcif_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
